// ===== src/first_order_ladrc_controller_core_defines.svh =====
// shared assertion macros
`ifndef FIRST_ORDER_LADRC_CONTROLLER_CORE_DEFINES_SVH
`define FIRST_ORDER_LADRC_CONTROLLER_CORE_DEFINES_SVH

// property must hold while out of reset
`define FOLC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication form
`define FOLC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/folc_pkg.sv =====
package folc_pkg;

  localparam int QW = 32;
  localparam logic signed [QW-1:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [QW-1:0] Q_MIN = 32'sh80000000;

  typedef enum logic [2:0] {
    REG_WC  = 3'd0,
    REG_WO  = 3'd1,
    REG_B0  = 3'd2,
    REG_DT  = 3'd3,
    REG_LIM = 3'd4
  } reg_idx_e;

  // sequencer steps, one per datapath operation
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_G1,
    ST_G2,
    ST_ERR,
    ST_BU,
    ST_G1E,
    ST_DZ1,
    ST_G2E,
    ST_DZ2,
    ST_Z1,
    ST_Z2,
    ST_SPE,
    ST_U0,
    ST_NUM,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_e;

  // multiply modes
  typedef enum logic [1:0] {
    MM_Q16,
    MM_DT
  } mul_mode_e;

  typedef struct packed {
    state_e step;
    logic   start_div;
    logic   in_take;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_sts_t;

  function automatic logic signed [QW-1:0] sat64(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'(Q_MAX);
    lo = 66'(Q_MIN);
    if (v > hi) begin
      return Q_MAX;
    end else if (v < lo) begin
      return Q_MIN;
    end
    return v[QW-1:0];
  endfunction

endpackage

// ===== src/first_order_ladrc_controller_core.sv =====
// First-order LADRC controller on signed Q16.16 data. One request (setpoint, measurement,
// feedforward) is taken at a time and yields one drive value. A request passes through
// the accepting idle state, 13 sequencer steps around one shared 32x33 multiplier, the
// bit-serial divider for the division by plant_gain (48 quotient bits and a done flag),
// one clamp step and the output state, where it waits for out_ready. Config writes go in
// only while idle is a rule for the user; the block itself does not enforce it.
module first_order_ladrc_controller_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] setpoint_i,
  input  logic signed [31:0] measurement_i,
  input  logic signed [31:0] feedforward_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] drive_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i
);
  import folc_pkg::*;

  logic [30:0] wc_q, wo_q, b0_q, lim_q;
  logic [31:0] dt_q;
  dp_cmd_t cmd;
  dp_sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q <= 31'd6553600;
      wo_q <= 31'd26214400;
      b0_q <= 31'd65536;
      dt_q <= 32'd4294967;
      lim_q <= 31'd6553600;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WC:  wc_q <= cfg_data_i[30:0];
        REG_WO:  wo_q <= cfg_data_i[30:0];
        REG_B0:  b0_q <= cfg_data_i[30:0];
        REG_DT:  dt_q <= cfg_data_i;
        REG_LIM: lim_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  folc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  folc_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .setpoint_i    (setpoint_i),
    .measurement_i (measurement_i),
    .feedforward_i (feedforward_i),
    .wc_i          (wc_q),
    .wo_i          (wo_q),
    .b0_i          (b0_q),
    .dt_i          (dt_q),
    .lim_i         (lim_q),
    .drive_o       (drive_o)
  );

endmodule

// ===== src/folc_divider.sv =====
module folc_divider (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [31:0]      num_i,
  input  logic [30:0]             den_i,
  output logic                    done_o,
  output logic signed [31:0]      quo_o
);
  import folc_pkg::*;

  // restoring divide of |num|<<16 (48 bits) by den, one bit a cycle
  logic [47:0] rem_q, rem_d;
  logic [47:0] quo_q, quo_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        neg_q, neg_d;
  logic        zero_q, zero_d;
  logic        nz_q, nz_d;
  logic        done_q, done_d;
  logic [48:0] trial;
  logic [31:0] mag;
  logic signed [49:0] sq;

  assign mag = num_i[31] ? 32'(-num_i) : 32'(num_i);
  assign trial = {rem_q, quo_q[47]} - {18'd0, den_i};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    neg_d = neg_q;
    zero_d = zero_q;
    nz_d = nz_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = {mag, 16'd0};
      cnt_d = 6'd48;
      busy_d = 1'b1;
      neg_d = num_i[31];
      zero_d = (den_i == '0);
      nz_d = (mag != '0);
    end else if (busy_q) begin
      if (trial[48]) begin
        rem_d = {rem_q[46:0], quo_q[47]};
        quo_d = {quo_q[46:0], 1'b0};
      end else begin
        rem_d = trial[47:0];
        quo_d = {quo_q[46:0], 1'b1};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
    zero_q <= zero_d;
    nz_q <= nz_d;
  end

  assign sq = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});

  always_comb begin
    if (zero_q) begin
      if (!nz_q) begin
        quo_o = '0;
      end else begin
        quo_o = neg_q ? Q_MIN : Q_MAX;
      end
    end else begin
      quo_o = sat64(66'(sq));
    end
  end
  assign done_o = done_q;

endmodule

// ===== src/folc_datapath.sv =====
module folc_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  folc_pkg::dp_cmd_t       cmd_i,
  output folc_pkg::dp_sts_t       sts_o,
  input  logic signed [31:0]      setpoint_i,
  input  logic signed [31:0]      measurement_i,
  input  logic signed [31:0]      feedforward_i,
  input  logic [30:0]             wc_i,
  input  logic [30:0]             wo_i,
  input  logic [30:0]             b0_i,
  input  logic [31:0]             dt_i,
  input  logic [30:0]             lim_i,
  output logic signed [31:0]      drive_o
);
  import folc_pkg::*;

  logic signed [31:0] sp_q, meas_q, ff_q;
  logic signed [31:0] z1_q, z1_d, z2_q, z2_d, u_q, u_d;
  logic signed [31:0] g1_q, g2_q, err_q, bu_q, dz1_q, dz2_q, acc_q, ul_q;
  logic signed [31:0] g1_d, g2_d, err_d, bu_d, dz1_d, dz2_d, acc_d, ul_d;
  logic signed [31:0] ma, mres, div_q;
  logic [32:0]        mb;
  mul_mode_e          mode;
  logic signed [65:0] prod, rnd;
  logic signed [32:0] lim_s, fin33;
  logic signed [31:0] fin;

  // shared multiplier operand selection
  always_comb begin
    ma = '0;
    mb = '0;
    mode = MM_Q16;
    case (cmd_i.step)
      ST_G2:  begin ma = 32'({1'b0, wo_i}); mb = 33'({2'b0, wo_i}); end
      ST_BU:  begin ma = u_q; mb = 33'({2'b0, b0_i}); end
      ST_G1E: begin ma = err_q; mb = 33'(g1_q); end
      ST_G2E: begin ma = err_q; mb = 33'(g2_q); end
      ST_Z1:  begin ma = dz1_q; mb = {1'b0, dt_i}; mode = MM_DT; end
      ST_Z2:  begin ma = dz2_q; mb = {1'b0, dt_i}; mode = MM_DT; end
      ST_U0:  begin ma = acc_q; mb = 33'({2'b0, wc_i}); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign prod = 66'(ma) * $signed(66'($signed(mb)));
  always_comb begin
    if (mode == MM_DT) begin
      rnd = (prod + 66'sh80000000) >>> 32;
    end else begin
      rnd = (prod + 66'sd32768) >>> 16;
    end
    mres = sat64(rnd);
  end

  assign lim_s = 33'({2'b0, lim_i});

  always_comb begin
    z1_d = z1_q; z2_d = z2_q; u_d = u_q;
    g1_d = g1_q; g2_d = g2_q; err_d = err_q; bu_d = bu_q;
    dz1_d = dz1_q; dz2_d = dz2_q; acc_d = acc_q; ul_d = ul_q;
    fin33 = 33'(ul_q) + 33'(ff_q);
    fin = sat64(66'(fin33));
    case (cmd_i.step)
      ST_G1:  g1_d = sat64(66'({1'b0, wo_i, 1'b0}));
      ST_G2:  g2_d = mres;
      ST_ERR: err_d = sat64(66'(z1_q) - 66'(meas_q));
      ST_BU:  bu_d = mres;
      ST_G1E: acc_d = mres;
      ST_DZ1: dz1_d = sat64(66'(z2_q) + 66'(bu_q) - 66'(acc_q));
      ST_G2E: acc_d = mres;
      ST_DZ2: dz2_d = sat64(-66'(acc_q));
      ST_Z1:  z1_d = sat64(66'(z1_q) + 66'(mres));
      ST_Z2:  z2_d = sat64(66'(z2_q) + 66'(mres));
      ST_SPE: acc_d = sat64(66'(sp_q) - 66'(z1_q));
      ST_U0:  acc_d = mres;
      ST_NUM: acc_d = sat64(66'(acc_q) - 66'(z2_q));
      ST_DIV: ul_d = div_q;
      ST_FIN: begin
        if (33'(fin) > lim_s) begin
          u_d = lim_s[31:0];
        end else if (33'(fin) < -lim_s) begin
          u_d = 32'(-lim_s);
        end else begin
          u_d = fin;
        end
      end
      default: ;
    endcase
  end

  // numerator is taken as it is formed in the last step before the divide
  folc_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start_div),
    .num_i   (acc_d),
    .den_i   (b0_i),
    .done_o  (sts_o.div_done),
    .quo_o   (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z1_q <= '0;
      z2_q <= '0;
      u_q <= '0;
    end else begin
      z1_q <= z1_d;
      z2_q <= z2_d;
      u_q <= u_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take) begin
      sp_q <= setpoint_i;
      meas_q <= measurement_i;
      ff_q <= feedforward_i;
    end
    g1_q <= g1_d; g2_q <= g2_d; err_q <= err_d; bu_q <= bu_d;
    dz1_q <= dz1_d; dz2_q <= dz2_d; acc_q <= acc_d; ul_q <= ul_d;
  end

  assign drive_o = u_q;

endmodule

// ===== src/folc_ctrl.sv =====
module folc_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output folc_pkg::dp_cmd_t       cmd_o,
  input  folc_pkg::dp_sts_t       sts_i
);
  import folc_pkg::*;
  `include "first_order_ladrc_controller_core_defines.svh"

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_G1;
      ST_G1:   state_d = ST_G2;
      ST_G2:   state_d = ST_ERR;
      ST_ERR:  state_d = ST_BU;
      ST_BU:   state_d = ST_G1E;
      ST_G1E:  state_d = ST_DZ1;
      ST_DZ1:  state_d = ST_G2E;
      ST_G2E:  state_d = ST_DZ2;
      ST_DZ2:  state_d = ST_Z1;
      ST_Z1:   state_d = ST_Z2;
      ST_Z2:   state_d = ST_SPE;
      ST_SPE:  state_d = ST_U0;
      ST_U0:   state_d = ST_NUM;
      ST_NUM:  state_d = ST_DIV;
      ST_DIV:  if (sts_i.div_done) state_d = ST_FIN;
      ST_FIN:  state_d = ST_OUT;
      ST_OUT:  if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.step = state_q;
    cmd_o.in_take = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.start_div = (state_q == ST_NUM);
    in_ready_o = (state_q == ST_IDLE);
    out_valid_o = (state_q == ST_OUT);
    // hold result until divider finishes
    if (state_q == ST_DIV && !sts_i.div_done) begin
      cmd_o.step = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `FOLC_ASSERT(a_no_dual, !(in_ready_o && out_valid_o), "ready and valid together")
  `FOLC_ASSERT_IMP(a_div_start, state_q == ST_NUM, ##1 state_q == ST_DIV, "divider not entered")
  `FOLC_ASSERT_IMP(a_out_hold, out_valid_o && !out_ready_i, ##1 out_valid_o, "result dropped")
  `FOLC_ASSERT_IMP(a_done_div, sts_i.div_done, state_q == ST_DIV, "stray divider done")

endmodule

// ===== tb/first_order_ladrc_controller_core_checker.sv =====
`timescale 1ns / 1ps

module first_order_ladrc_controller_core_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [31:0] setpoint_i,
  input  logic signed [31:0] measurement_i,
  input  logic signed [31:0] feedforward_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] drive_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import folc_pkg::*;

  localparam longint LMAX = 64'sd2147483647;
  localparam longint LMIN = -64'sd2147483648;

  longint wc, wo, b0, dt, lim;
  longint z_state, z_dist, u_last;
  logic signed [31:0] drive_fifo[$];

  function automatic longint clip(input longint v);
    if (v > LMAX) return LMAX;
    if (v < LMIN) return LMIN;
    return v;
  endfunction

  function automatic longint qmul16(input longint a, input longint b);
    return clip((a * b + 64'sd32768) >>> 16);
  endfunction

  function automatic longint qmul_step(input longint a, input longint d);
    return clip((a * d + 64'sd2147483648) >>> 32);
  endfunction

  function automatic longint qdiv_gain(input longint num, input longint den);
    if (den == 0) begin
      if (num > 0) return LMAX;
      if (num < 0) return LMIN;
      return 0;
    end
    return clip((num * 64'sd65536) / den);
  endfunction

  // advances the observer and returns the clamped drive
  function automatic logic signed [31:0] ladrc_drive(input longint sp, input longint meas,
                                                     input longint ff);
    longint g1, g2, err, dz1, dz2, u0, ul, fin;
    g1 = clip(2 * wo);
    g2 = qmul16(wo, wo);
    err = clip(z_state - meas);
    dz1 = clip(z_dist + qmul16(b0, u_last) - qmul16(g1, err));
    dz2 = clip(-qmul16(g2, err));
    z_state = clip(z_state + qmul_step(dz1, dt));
    z_dist = clip(z_dist + qmul_step(dz2, dt));
    u0 = qmul16(wc, clip(sp - z_state));
    ul = qdiv_gain(clip(u0 - z_dist), b0);
    fin = clip(ul + ff);
    if (fin > lim) begin
      fin = lim;
    end else if (fin < -lim) begin
      fin = -lim;
    end
    u_last = fin;
    return fin[31:0];
  endfunction

  task automatic note_fail(input string what, input logic signed [31:0] exp_v,
                           input logic signed [31:0] act_v);
    if (fail_count_o < 10) begin
      $display("%t drive %s: expected %0d actual %0d", $realtime, what, exp_v, act_v);
    end
    fail_count_o <= fail_count_o + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [31:0] exp_v;
    if (!rst_ni) begin
      wc = 6553600;
      wo = 26214400;
      b0 = 65536;
      dt = 4294967;
      lim = 6553600;
      z_state = 0;
      z_dist = 0;
      u_last = 0;
      drive_fifo.delete();
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_WC:  wc = longint'({1'b0, cfg_data_i[30:0]});
          REG_WO:  wo = longint'({1'b0, cfg_data_i[30:0]});
          REG_B0:  b0 = longint'({1'b0, cfg_data_i[30:0]});
          REG_DT:  dt = longint'({32'd0, cfg_data_i});
          REG_LIM: lim = longint'({1'b0, cfg_data_i[30:0]});
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (drive_fifo.size() == 0) begin
          note_fail("with no request pending", 32'sd0, drive_i);
        end else begin
          exp_v = drive_fifo.pop_front();
          if (drive_i !== exp_v) note_fail("mismatch", exp_v, drive_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        drive_fifo.push_back(ladrc_drive(setpoint_i, measurement_i, feedforward_i));
      end
      pending_o <= drive_fifo.size();
    end
  end

endmodule

// ===== tb/first_order_ladrc_controller_core_tb.sv =====
`timescale 1ns / 1ps

module first_order_ladrc_controller_core_tb;
  import folc_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int CHUNKS = 12;
  localparam int CHUNK_ITEMS = 140;
  localparam logic [2:0] CFG_IDX_UNUSED = 3'd7;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [31:0] setpoint_i;
  logic signed [31:0] measurement_i;
  logic signed [31:0] feedforward_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] drive_o;
  logic               cfg_we_i;
  logic [2:0]         cfg_idx_i;
  logic [31:0]        cfg_data_i;
  int                 fail_count;
  int                 pending;
  int                 send_idle;
  int                 recv_idle;
  int                 stall_cycles;

  first_order_ladrc_controller_core u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .setpoint_i, .measurement_i,
    .feedforward_i, .out_valid_o, .out_ready_i, .drive_o, .cfg_we_i, .cfg_idx_i,
    .cfg_data_i
  );

  first_order_ladrc_controller_core_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .setpoint_i,
    .measurement_i, .feedforward_i, .out_valid_i(out_valid_o), .out_ready_i,
    .drive_i(drive_o), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("first_order_ladrc_controller_core_tb NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [31:0] rand_q();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      5, 6, 7:       return $urandom;
      default: begin
        case ($urandom_range(4))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return 32'd0;
          3: return 32'hffff_ffff;
          default: return 32'd1;
        endcase
      end
    endcase
  endfunction

  task automatic push_request(input logic [31:0] sp, input logic [31:0] meas,
                              input logic [31:0] ff);
    if ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 90)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    setpoint_i <= sp;
    measurement_i <= meas;
    feedforward_i <= ff;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic directed_extremes(input int count);
    logic [31:0] ext[5];
    ext = '{Q_MAX, Q_MIN, 32'd0, 32'd1, 32'hffff_ffff};
    for (int i = 0; i < count; i++) begin
      push_request(ext[i % 5], ext[(i / 5) % 5], ext[(i * 3 + 1) % 5]);
    end
  endtask

  initial begin
    logic [31:0] hi_bit;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    setpoint_i = '0;
    measurement_i = '0;
    feedforward_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    send_idle = 13;
    recv_idle = 74;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int c = 0; c < CHUNKS; c++) begin
      case (c / 4)
        0: begin send_idle = 13; recv_idle = 74; end
        1: begin send_idle = 74; recv_idle = 13; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      if (c > 0) begin
        drain();
        hi_bit = {1'($urandom_range(1)), 31'd0};
        case (c)
          1: begin
            write_reg(REG_WC, 32'hffff_ffff);
            write_reg(REG_WO, 32'h7fff_ffff);
            write_reg(REG_B0, 32'hffff_ffff);
            write_reg(REG_DT, 32'hffff_ffff);
            write_reg(REG_LIM, 32'h7fff_ffff);
          end
          2: begin
            write_reg(REG_WC, 32'h8000_0000);
            write_reg(REG_WO, 32'd0);
            write_reg(REG_B0, 32'd0);
            write_reg(REG_DT, 32'd0);
            write_reg(REG_LIM, 32'd0);
            write_reg(CFG_IDX_UNUSED, 32'h0001_0000);
          end
          3: begin
            write_reg(REG_WC, 32'd1);
            write_reg(REG_WO, 32'h7fff_ffff);
            write_reg(REG_B0, 32'd1);
            write_reg(REG_DT, 32'hffff_ffff);
            write_reg(REG_LIM, 32'h7fff_ffff);
          end
          default: begin
            write_reg(REG_WC, hi_bit | (($urandom_range(9) < 7) ?
                                        $urandom_range(0, 500 * 65536) : $urandom));
            write_reg(REG_WO, hi_bit | (($urandom_range(9) < 7) ?
                                        $urandom_range(0, 2000 * 65536) : $urandom));
            write_reg(REG_B0, hi_bit | (($urandom_range(9) < 7) ?
                                        $urandom_range(1, 50 * 65536) : $urandom));
            write_reg(REG_DT, ($urandom_range(9) < 7) ?
                              $urandom_range(0, 32'h0400_0000) : $urandom);
            write_reg(REG_LIM, hi_bit | (($urandom_range(9) < 7) ?
                                         $urandom_range(0, 1000 * 65536) : $urandom));
          end
        endcase
      end
      case (c)
        0:       directed_extremes(20);
        1, 2, 3: directed_extremes(6);
        default: ;
      endcase
      for (int i = 0; i < CHUNK_ITEMS; i++) begin
        push_request(rand_q(), rand_q(), rand_q());
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("first_order_ladrc_controller_core_tb OK");
    end else begin
      $display("first_order_ladrc_controller_core_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/folc_pkg.sv
src/folc_divider.sv
src/folc_datapath.sv
src/folc_ctrl.sv
src/first_order_ladrc_controller_core.sv
tb/first_order_ladrc_controller_core_checker.sv
tb/first_order_ladrc_controller_core_tb.sv
